[src/aes128_cbc_padded_engine_defines.svh]
// Assertion macros for the AES-128 CBC engine checker.
// Used by the port-level checker; no other dependencies.
`ifndef AES128_CBC_PADDED_ENGINE_DEFINES_SVH
`define AES128_CBC_PADDED_ENGINE_DEFINES_SVH

// Implication checked on every clock, masked during reset.
`define ACBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ACBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/acbc_pkg.sv]
// Package for the AES-128 CBC engine: payload types, register codes, AES helpers.
// No dependencies.
`timescale 1ns / 1ps
package acbc_pkg;

    typedef struct packed {
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  valid_bytes;
        logic        first;
        logic        final_req;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_hi;
        logic [63:0] out_lo;
        logic [4:0]  out_bytes;
        logic        out_last;
        logic        pad_error;
    } out_item_t;

    // Job handed from front to back: a prepared block plus its handling.
    typedef struct packed {
        logic [127:0] blk;       // padded plaintext or ciphertext
        logic         load_iv;   // restart chaining from the vector
        logic         last;      // final block of message
        logic         extra;     // encrypt: follow with a full pad block
    } job_t;

    localparam int unsigned JobQDepth = 2;
    localparam int unsigned BlkBytes = 16;

    typedef enum logic [2:0] {
        REG_KEY_HI    = 3'd0,
        REG_KEY_LO    = 3'd1,
        REG_IV_HI     = 3'd2,
        REG_IV_LO     = 3'd3,
        REG_DIRECTION = 3'd4
    } reg_idx_t;

    localparam logic [7:0] Sbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (Sbox[i] == v) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte n of a block, byte 0 at the top.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
        return s[127 - 8*n -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic final_rnd);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = Sbox[get_byte(s, i + 4*((c + i) % 4))];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (final_rnd) begin
                r[127 - 32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                r[127 - 32*c -: 32] = {
                    xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                    xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return r ^ k;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r, x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = xtime(x);
        end
        return r;
    endfunction

    // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, then InvMixColumns.
    function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic final_rnd);
        logic [7:0] t [16];
        logic [127:0] u, r;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*((c + i) % 4)] = get_byte(s, i + 4*c);
            end
        end
        for (int i = 0; i < 16; i++) begin
            u[127 - 8*i -: 8] = inv_sbox(t[i]);
        end
        u = u ^ k;
        if (final_rnd) begin
            r = u;
        end else begin
            for (int c = 0; c < 4; c++) begin
                a0 = get_byte(u, 4*c); a1 = get_byte(u, 4*c+1);
                a2 = get_byte(u, 4*c+2); a3 = get_byte(u, 4*c+3);
                r[127 - 32*c -: 32] = {
                    gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9),
                    gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13),
                    gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11),
                    gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14)};
            end
        end
        return r;
    endfunction

    // One key-schedule step: round key n from round key n-1.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[src/acbc_front.sv]
// Front end: accepts input beats, pads encrypt remainders, queues jobs.
// Depends on acbc_pkg.
`timescale 1ns / 1ps
module acbc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  acbc_pkg::in_item_t din,
    input  logic              dir,
    output logic              job_valid,
    input  logic              job_take,
    output acbc_pkg::job_t    job
);
    acbc_pkg::job_t job_q_reg [acbc_pkg::JobQDepth];
    logic           wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    acbc_pkg::job_t new_job;
    logic [4:0]     n;
    logic [7:0]     pad;
    logic           do_push;

    assign full      = (cnt_reg == 2'(acbc_pkg::JobQDepth));
    assign do_push   = push && !full;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = job_q_reg[rd_ptr_reg];

    always_comb
    begin
        if (!din.final_req || din.valid_bytes > 5'd16) begin
            n = 5'd16;
        end else begin
            n = din.valid_bytes;
        end
        pad = 8'(5'd16 - n);
        new_job.blk = {din.data_hi, din.data_lo};
        if (!dir) begin
            for (int i = 0; i < acbc_pkg::BlkBytes; i++) begin
                if (5'(i) >= n) begin
                    new_job.blk[127 - 8*i -: 8] = pad;
                end
            end
        end
        new_job.load_iv = din.first;
        new_job.last    = din.final_req;
        new_job.extra   = !dir && din.final_req && (n == 5'd16);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            job_q_reg[wr_ptr_reg] <= new_job;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ job_take;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(job_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

[src/acbc_core.sv]
// Back end: iterative AES round unit with CBC chaining and pad stripping.
// Depends on acbc_pkg; round keys come from the top level's key store.
`timescale 1ns / 1ps
module acbc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_take,
    input  acbc_pkg::job_t    job,
    input  logic              dir,
    input  logic [127:0]      iv,
    output logic [3:0]        rk_idx,
    input  logic [127:0]      rk,
    output logic              res_valid,
    input  logic              res_take,
    output acbc_pkg::out_item_t res
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t       state_reg, state_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] ct_reg, ct_next;      // decrypt: incoming ciphertext
    logic         last_reg, last_next;
    logic         extra_reg, extra_next;
    logic         res_valid_reg, res_valid_next;
    acbc_pkg::out_item_t res_reg, res_next;
    logic [127:0] cv, rnd_out;
    logic [3:0]   key_rnd;
    // Decrypt output, finished from st_reg and the chain value while in S_OUT.
    logic [127:0] dec_blk;
    logic [4:0]   keep_o;
    logic         err_o;
    logic [7:0]   padd;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Encrypt walks keys 0..10, decrypt 10..0; rnd counts rounds done.
    // Outside S_RUN the whitening key (round 0) is selected.
    assign key_rnd = (state_reg == S_RUN) ? rnd_reg : 4'd0;
    assign rk_idx  = dir ? (4'd10 - key_rnd) : key_rnd;
    assign cv      = (state_reg == S_IDLE && job.load_iv) ? iv : chain_reg;
    assign rnd_out = dir ? acbc_pkg::dec_round(st_reg, rk, rnd_reg == 4'd10)
                         : acbc_pkg::enc_round(st_reg, rk, rnd_reg == 4'd10);
    assign job_take = (state_reg == S_IDLE) && job_valid;

    always_comb
    begin
        padd    = st_reg[7:0] ^ chain_reg[7:0];
        err_o   = last_reg && (padd == 8'd0 || padd > 8'd16);
        keep_o  = !last_reg ? 5'd16 : (err_o ? 5'd0 : 5'(8'd16 - padd));
        dec_blk = st_reg ^ chain_reg;
        for (int i = 0; i < acbc_pkg::BlkBytes; i++) begin
            if (5'(i) >= keep_o) begin
                dec_blk[127 - 8*i -: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        st_next        = st_reg;
        chain_next     = chain_reg;
        ct_next        = ct_reg;
        last_next      = last_reg;
        extra_next     = extra_reg;
        res_valid_next = res_valid_reg && !res_take;
        res_next       = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid) begin
                    chain_next = cv;
                    ct_next    = job.blk;
                    last_next  = job.last;
                    extra_next = job.extra;
                    st_next    = (dir ? job.blk : (job.blk ^ cv)) ^ rk;
                    rnd_next   = 4'd1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                st_next  = rnd_out;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd10) begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_take) begin
                    res_valid_next = 1'b1;
                    if (dir) begin
                        res_next = '{out_hi: dec_blk[127:64], out_lo: dec_blk[63:0],
                                     out_bytes: keep_o, out_last: last_reg,
                                     pad_error: err_o};
                        chain_next = ct_reg;
                        state_next = S_IDLE;
                    end else begin
                        res_next = '{out_hi: st_reg[127:64], out_lo: st_reg[63:0],
                                     out_bytes: 5'd16,
                                     out_last: last_reg && !extra_reg, pad_error: 1'b0};
                        chain_next = st_reg;
                        if (extra_reg) begin
                            extra_next = 1'b0;
                            st_next    = {16{8'h10}} ^ st_reg ^ rk;
                            rnd_next   = 4'd1;
                            state_next = S_RUN;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        ct_reg  <= ct_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rnd_reg       <= 4'd0;
            chain_reg     <= '0;
            last_reg      <= 1'b0;
            extra_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            chain_reg     <= chain_next;
            last_reg      <= last_next;
            extra_reg     <= extra_next;
            res_valid_reg <= res_valid_next;
        end
    end
endmodule

[src/acbc_keysched.sv]
// Key store: expands the key one round per cycle after a key write.
// Depends on acbc_pkg.
`timescale 1ns / 1ps
module acbc_keysched (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [3:0]   rd_idx,
    output logic [127:0] rd_key,
    output logic         busy
);
    logic [127:0] rk_reg [11];
    logic [3:0]   step_reg, step_next;
    logic [7:0]   rc_reg, rc_next;
    logic         busy_reg, busy_next;
    logic [127:0] nk;

    assign busy   = busy_reg;
    assign rd_key = rk_reg[rd_idx];
    assign nk     = acbc_pkg::key_step(rk_reg[step_reg - 4'd1], rc_reg);

    always_comb
    begin
        step_next = step_reg;
        rc_next   = rc_reg;
        busy_next = busy_reg;
        if (start) begin
            step_next = 4'd1;
            rc_next   = 8'h01;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            rc_next   = acbc_pkg::xtime(rc_reg);
            busy_next = (step_reg != 4'd10);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            rk_reg[0] <= key;
        end else if (busy_reg) begin
            rk_reg[step_reg] <= nk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= 4'd0;
            rc_reg   <= 8'h01;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            rc_reg   <= rc_next;
            busy_reg <= busy_next;
        end
    end
endmodule

[src/aes128_cbc_padded_engine.sv]
// Top level of the AES-128 CBC engine with PKCS#7-style padding.
// Depends on acbc_pkg, acbc_front, acbc_keysched, acbc_core.
//
// Use:
//   Input channel (push/full) takes one beat per 16-byte block. Result
//   channel (empty/pop) shows the oldest result while empty is low.
//   Configuration via APB at 8-byte strides (key_hi, key_lo, iv_hi, iv_lo,
//   direction); pready is tied high, reads return the written values.
// Processing:
//   A block is loaded into the shared round unit, runs its ten rounds
//   there and then forms its result; the unit takes the next job only
//   after that. An encrypt final full block then runs the extra pad block
//   through ten more rounds and another result.
//   Key writes start an expansion, one round key per cycle.
// Flow:
//   A two-entry job queue decouples input from the round unit; a result
//   register decouples the round unit from the result channel, so a stalled
//   receiver stops the round unit only once a result is already waiting.
// Reset:
//   Clears queue, chaining value (zero), registers and result valid.
//   Round keys are undefined until a key register is written.
`timescale 1ns / 1ps
module aes128_cbc_padded_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  acbc_pkg::in_item_t    din,
    output logic                  empty,
    input  logic                  pop,
    output acbc_pkg::out_item_t   dout,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    logic [63:0] key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic        dir_reg;
    logic        wr_en, key_start, ks_busy;
    logic [2:0]  ridx;
    logic        job_valid, job_take, res_valid;
    acbc_pkg::job_t job;
    logic [3:0]  rk_idx;
    logic [127:0] rk;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[5:3];
    assign key_start = wr_en && (ridx == acbc_pkg::REG_KEY_HI || ridx == acbc_pkg::REG_KEY_LO);

    always_comb
    begin
        unique case (ridx)
            acbc_pkg::REG_KEY_HI:    prdata = key_hi_reg;
            acbc_pkg::REG_KEY_LO:    prdata = key_lo_reg;
            acbc_pkg::REG_IV_HI:     prdata = iv_hi_reg;
            acbc_pkg::REG_IV_LO:     prdata = iv_lo_reg;
            acbc_pkg::REG_DIRECTION: prdata = {63'd0, dir_reg};
            default:                 prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            iv_hi_reg  <= '0;
            iv_lo_reg  <= '0;
            dir_reg    <= 1'b0;
        end else if (wr_en) begin
            unique case (ridx)
                acbc_pkg::REG_KEY_HI:    key_hi_reg <= pwdata;
                acbc_pkg::REG_KEY_LO:    key_lo_reg <= pwdata;
                acbc_pkg::REG_IV_HI:     iv_hi_reg  <= pwdata;
                acbc_pkg::REG_IV_LO:     iv_lo_reg  <= pwdata;
                acbc_pkg::REG_DIRECTION: dir_reg    <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    // Expansion starts the cycle after the write so it sees the new key.
    logic start_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= 1'b0;
        end else begin
            start_reg <= key_start;
        end
    end

    acbc_front u_front (
        .clk, .rst_n, .push, .full, .din, .dir(dir_reg),
        .job_valid, .job_take, .job
    );

    acbc_keysched u_ks (
        .clk, .rst_n, .start(start_reg), .key({key_hi_reg, key_lo_reg}),
        .rd_idx(rk_idx), .rd_key(rk), .busy(ks_busy)
    );

    acbc_core u_core (
        .clk, .rst_n, .job_valid(job_valid && !ks_busy && !start_reg), .job_take,
        .job, .dir(dir_reg), .iv({iv_hi_reg, iv_lo_reg}), .rk_idx, .rk,
        .res_valid, .res_take(pop && res_valid), .res(dout)
    );

    assign empty = !res_valid;
endmodule

[src/acbc_checker.sv]
// Port-level checker for the AES-128 CBC engine, bound to the top level.
// Depends on acbc_pkg and aes128_cbc_padded_engine_defines.svh.
`timescale 1ns / 1ps
`include "aes128_cbc_padded_engine_defines.svh"
module acbc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input logic                pready,
    input acbc_pkg::out_item_t dout
);
    `ACBC_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `ACBC_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(dout), "result not held")
    `ACBC_ASSERT_IMPL(a_bytes, clk, rst_n, !empty, dout.out_bytes <= 5'd16, "out_bytes too large")
    `ACBC_ASSERT_IMPL(a_err, clk, rst_n, !empty && dout.pad_error, dout.out_last && dout.out_bytes == 5'd0, "pad_error without empty last block")
endmodule

bind aes128_cbc_padded_engine acbc_checker u_chk (
    .clk, .rst_n, .empty, .pop, .pready, .dout
);

[test/testbench.sv]
// Self-checking testbench for aes128_cbc_padded_engine: CBC encrypt with padding and
// decrypt with pad stripping, checked against a built-in AES-128 predictor.
// Depends on acbc_pkg (payload types, register codes) and the engine RTL.
`timescale 1ns / 1ps
module testbench;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    acbc_pkg::in_item_t    din;
    logic        empty;
    logic        pop;
    acbc_pkg::out_item_t   dout;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    aes128_cbc_padded_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .din(din),
        .empty(empty), .pop(pop), .dout(dout),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: tables, round keys, chaining value, shadow registers.
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [127:0] rkey [11];
    logic [127:0] chain_blk;
    logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
    logic         dir_r;

    acbc_pkg::in_item_t  pending_blocks [$];
    acbc_pkg::out_item_t expected_blocks [$];
    int        mismatches;
    int        block_beats;
    int        result_beats;
    int        msg_count;
    int        in_gap;
    int        out_gap;
    bit        idle_on;
    logic [127:0] gen_chain;   // stimulus-side chain for building ciphertext

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i])
            begin
                r = r ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    // S-box from the GF(2^8) inverse and the affine map.
    task automatic build_tables();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            if (x == 0)
            begin
                inv = 8'h00;
            end
            else
            begin
                for (int k = 0; k < 254; k++)
                begin
                    inv = gmul(inv, 8'(x));
                end
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = 8'(x);
        end
    endtask

    task automatic expand_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi_r, key_lo_r};
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
                     fwd_sub[t[31:24]]};
                rc = gmul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
        begin
            rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        end
    endtask

    function automatic logic [127:0] aes_fwd(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] v;
        v = blk ^ rkey[0];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++)
            begin
                s[i] = fwd_sub[v[127-8*i -: 8]];
            end
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[i+4*c] = s[i+4*((c+i)%4)];
                end
            end
            for (int c = 0; c < 4; c++) begin
                if (r < 10)
                begin
                    v[127-32*c -: 32] = {
                        gmul(t[4*c],8'd2) ^ gmul(t[4*c+1],8'd3) ^ t[4*c+2] ^ t[4*c+3],
                        t[4*c] ^ gmul(t[4*c+1],8'd2) ^ gmul(t[4*c+2],8'd3) ^ t[4*c+3],
                        t[4*c] ^ t[4*c+1] ^ gmul(t[4*c+2],8'd2) ^ gmul(t[4*c+3],8'd3),
                        gmul(t[4*c],8'd3) ^ t[4*c+1] ^ t[4*c+2] ^ gmul(t[4*c+3],8'd2)};
                end
                else
                begin
                    v[127-32*c -: 32] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
                end
            end
            v = v ^ rkey[r];
        end
        return v;
    endfunction

    function automatic logic [127:0] aes_inv(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] v;
        v = blk ^ rkey[10];
        for (int r = 9; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[i+4*((c+i)%4)] = v[127-8*(i+4*c) -: 8];
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                v[127-8*i -: 8] = inv_sub[t[i]];
            end
            v = v ^ rkey[r];
            if (r > 0)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    s[i] = v[127-8*i -: 8];
                end
                for (int c = 0; c < 4; c++)
                begin
                    v[127-32*c -: 32] = {
                        gmul(s[4*c],8'd14) ^ gmul(s[4*c+1],8'd11)
                            ^ gmul(s[4*c+2],8'd13) ^ gmul(s[4*c+3],8'd9),
                        gmul(s[4*c],8'd9) ^ gmul(s[4*c+1],8'd14)
                            ^ gmul(s[4*c+2],8'd11) ^ gmul(s[4*c+3],8'd13),
                        gmul(s[4*c],8'd13) ^ gmul(s[4*c+1],8'd9)
                            ^ gmul(s[4*c+2],8'd14) ^ gmul(s[4*c+3],8'd11),
                        gmul(s[4*c],8'd11) ^ gmul(s[4*c+1],8'd13)
                            ^ gmul(s[4*c+2],8'd9) ^ gmul(s[4*c+3],8'd14)};
                end
            end
        end
        return v;
    endfunction

    // Expected result beats for one accepted block beat.
    task automatic predict_block(input acbc_pkg::in_item_t it);
        logic [127:0] b;
        acbc_pkg::out_item_t o;
        int           n, keep;
        logic [7:0]   pad;
        if (it.first)
        begin
            chain_blk = {iv_hi_r, iv_lo_r};
        end
        b = {it.data_hi, it.data_lo};
        o = '0;
        if (!dir_r)
        begin
            n = (it.valid_bytes > 16) ? 16 : it.valid_bytes;
            if (!it.final_req)
            begin
                n = 16;
            end
            for (int i = n; i < 16; i++)
            begin
                b[127-8*i -: 8] = 8'(16 - n);
            end
            chain_blk = aes_fwd(b ^ chain_blk);
            o = '{chain_blk[127:64], chain_blk[63:0], 5'd16, it.final_req && n < 16, 1'b0};
            expected_blocks.push_back(o);
            if (it.final_req && n == 16)
            begin
                chain_blk = aes_fwd({16{8'h10}} ^ chain_blk);
                o = '{chain_blk[127:64], chain_blk[63:0], 5'd16, 1'b1, 1'b0};
                expected_blocks.push_back(o);
            end
        end
        else
        begin
            b = aes_inv(b) ^ chain_blk;
            chain_blk = {it.data_hi, it.data_lo};
            keep = 16;
            o.pad_error = 1'b0;
            if (it.final_req)
            begin
                pad = b[7:0];
                if (pad == 8'd0 || pad > 8'd16)
                begin
                    o.pad_error = 1'b1;
                    keep = 0;
                end
                else
                begin
                    keep = 16 - pad;
                end
                for (int i = keep; i < 16; i++)
                begin
                    b[127-8*i -: 8] = 8'h00;
                end
            end
            o.out_hi = b[127:64];
            o.out_lo = b[63:0];
            o.out_bytes = 5'(keep);
            o.out_last = it.final_req;
            expected_blocks.push_back(o);
        end
    endtask

    task automatic reg_write(input acbc_pkg::reg_idx_t idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            acbc_pkg::REG_KEY_HI:    begin key_hi_r = val; expand_keys(); end
            acbc_pkg::REG_KEY_LO:    begin key_lo_r = val; expand_keys(); end
            acbc_pkg::REG_IV_HI:     iv_hi_r = val;
            acbc_pkg::REG_IV_LO:     iv_lo_r = val;
            acbc_pkg::REG_DIRECTION: dir_r = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] ih, input logic [63:0] il, input logic d);
        reg_write(acbc_pkg::REG_KEY_HI, kh);
        reg_write(acbc_pkg::REG_KEY_LO, kl);
        reg_write(acbc_pkg::REG_IV_HI, ih);
        reg_write(acbc_pkg::REG_IV_LO, il);
        reg_write(acbc_pkg::REG_DIRECTION, {63'd0, d});
        // key expansion runs on after the write
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [127:0] rand_blk();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Plaintext message for the encrypt direction; vb is the final beat's count.
    task automatic queue_plain(input int nblk, input int vb, input bit restart);
        acbc_pkg::in_item_t it;
        for (int i = 0; i < nblk; i++) begin
            {it.data_hi, it.data_lo} = rand_blk();
            it.valid_bytes = (i == nblk - 1) ? 5'(vb) : 5'($urandom_range(0, 31));
            it.first = (i == 0) && restart;
            it.final_req = (i == nblk - 1);
            pending_blocks.push_back(it);
        end
        msg_count++;
    endtask

    // Ciphertext message whose decrypted last byte is pad.
    task automatic queue_cipher(input int nblk, input logic [7:0] pad, input bit restart);
        acbc_pkg::in_item_t it;
        logic [127:0] p;
        if (restart)
        begin
            gen_chain = {iv_hi_r, iv_lo_r};
        end
        for (int i = 0; i < nblk; i++) begin
            p = rand_blk();
            if (i == nblk - 1)
            begin
                p[7:0] = pad;
            end
            gen_chain = aes_fwd(p ^ gen_chain);
            {it.data_hi, it.data_lo} = gen_chain;
            it.valid_bytes = 5'($urandom_range(0, 31));
            it.first = (i == 0) && restart;
            it.final_req = (i == nblk - 1);
            pending_blocks.push_back(it);
        end
        msg_count++;
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_blocks.size() != 0 || push || expected_blocks.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    // Random phase: mostly well-formed messages, some raw noise blocks.
    task automatic random_phase(input int nitems);
        int   sent, nb, pick;
        logic [7:0] pad;
        acbc_pkg::in_item_t it;
        sent = 0;
        while (sent < nitems) begin
            nb = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // noise: random block, random flags; the chain follows the ciphertext
                {it.data_hi, it.data_lo} = rand_blk();
                it.valid_bytes = 5'($urandom_range(0, 31));
                it.first = 1'($urandom);
                it.final_req = 1'($urandom);
                pending_blocks.push_back(it);
                gen_chain = {it.data_hi, it.data_lo};
                nb = 1;
            end
            else if (!dir_r)
            begin
                queue_plain(nb, $urandom_range(0, 31), pick != 1);
            end
            else
            begin
                pad = 8'($urandom_range(1, 16));
                if (pick == 2)
                begin
                    pad = 8'($urandom_range(0, 255));
                end
                queue_cipher(nb, pad, pick != 1);
            end
            sent += nb;
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // Input driver: one block beat per accepted push, random gap bursts
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : block_driver
        logic nxt;
        if (rst_n)
        begin
            nxt = 1'b0;
            if (push && !full)
            begin
                predict_block(din);
                block_beats++;
            end
            if (push && full)
            begin
                nxt = 1'b1;
            end
            else if (in_gap > 0)
            begin
                in_gap--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                in_gap = $urandom_range(0, 5);
            end
            else if (pending_blocks.size() != 0)
            begin
                nxt = 1'b1;
                din <= pending_blocks.pop_front();
            end
            push <= nxt;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compares each popped beat with the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        acbc_pkg::out_item_t want;
        logic      nxt;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                result_beats++;
                if (expected_blocks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result beat: %h", dout);
                    end
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (dout.out_hi !== want.out_hi || dout.out_lo !== want.out_lo
                        || dout.out_bytes !== want.out_bytes
                        || dout.out_last !== want.out_last
                        || dout.pad_error !== want.pad_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp hi=%h lo=%h bytes=%0d last=%b err=%b",
                                     want.out_hi, want.out_lo, want.out_bytes,
                                     want.out_last, want.pad_error);
                            $display("          got hi=%h lo=%h bytes=%0d last=%b err=%b",
                                     dout.out_hi, dout.out_lo, dout.out_bytes,
                                     dout.out_last, dout.pad_error);
                        end
                    end
                end
            end
            nxt = 1'b1;
            if (out_gap > 0)
            begin
                out_gap--;
                nxt = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                out_gap = $urandom_range(0, 5);
                nxt = 1'b0;
            end
            pop <= nxt;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        din = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        key_hi_r = '0; key_lo_r = '0; iv_hi_r = '0; iv_lo_r = '0; dir_r = 1'b0;
        chain_blk = '0;
        gen_chain = '0;
        mismatches = 0; block_beats = 0; result_beats = 0; msg_count = 0;
        in_gap = 0; out_gap = 0;
        idle_on = 1'b1;
        build_tables();
        expand_keys();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed encrypt: empty final, full final (extra pad block), partial,
        // oversized count, ignored count on non-final blocks, data extremes.
        configure('0, '0, '0, '0, 1'b0);
        queue_plain(1, 0, 1);
        queue_plain(1, 16, 1);
        queue_plain(2, 15, 1);
        queue_plain(1, 1, 1);
        queue_plain(1, 31, 1);
        queue_plain(1, 17, 0);
        pending_blocks.push_back('{'1, '1, 5'd3, 1'b1, 1'b0});
        pending_blocks.push_back('{'0, '0, 5'd8, 1'b0, 1'b1});
        drain();

        // Directed decrypt: good pads at both ends, zero pad, oversize pads,
        // chaining carried across messages without a restart.
        configure('1, '1, '1, '1, 1'b1);
        queue_cipher(1, 8'd1, 1);
        queue_cipher(2, 8'd16, 1);
        queue_cipher(1, 8'd0, 1);
        queue_cipher(1, 8'd17, 0);
        queue_cipher(1, 8'hff, 1);
        queue_cipher(2, 8'd5, 0);
        pending_blocks.push_back('{'1, '0, 5'd31, 1'b0, 1'b0});
        drain();

        configure({$urandom, $urandom}, {$urandom, $urandom}, '0, '1, 1'b0);
        random_phase(145);
        configure({$urandom, $urandom}, {$urandom, $urandom}, '1, '0, 1'b1);
        random_phase(145);
        configure('1, '0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        random_phase(145);
        configure('0, '1, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        random_phase(145);
        configure({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        random_phase(145);
        configure({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        random_phase(145);
        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        configure({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        random_phase(70);
        configure({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        random_phase(70);

        $display("covered %0d messages: %0d block beats in, %0d result beats out",
                 msg_count, block_beats, result_beats);
        $display("both directions, key/iv extremes, all pad cases; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
